[rtl/ska_pkg.sv]
`timescale 1ns / 1ps

package ska_pkg;

	// Field widths of the request and result beats
	localparam int SIZE_W = 9;
	localparam int PAGE_W = 4;
	localparam int POS_W  = 8;

	typedef struct packed {
		logic [SIZE_W-1:0] rect_width;
		logic [SIZE_W-1:0] rect_height;
	} req_t;

	typedef struct packed {
		logic              placed;
		logic [PAGE_W-1:0] page_index;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
	} res_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_P1_RD,
		ST_P1_USE,
		ST_P2_RD,
		ST_P2_PRE,
		ST_P2_WIN,
		ST_P2_CMP,
		ST_DECIDE,
		ST_WRITE,
		ST_DONE
	} state_t;

endpackage

[rtl/ska_max_unit.sv]
`timescale 1ns / 1ps

// Shared max / less-than unit on two column heights
module ska_max_unit #(
	parameter int HW = 9
) (
	input  logic [HW-1:0] a,
	input  logic [HW-1:0] b,
	output logic [HW-1:0] max_val,
	output logic          a_lt_b
);

	assign a_lt_b  = (a < b);
	assign max_val = a_lt_b ? b : a;

endmodule

[rtl/ska_engine.sv]
`timescale 1ns / 1ps

// Skyline search sequencer: block-wise window maximum over each page,
// then raise the chosen columns.
module ska_engine #(
	parameter int PAGES   = 1,
	parameter int COLUMNS = 256,
	parameter int ROWS    = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ska_pkg::req_t req_data,
	input  logic          out_free,
	output logic          done,
	output ska_pkg::res_t result
);

	localparam int CW    = $clog2(COLUMNS);
	localparam int HW    = $clog2(ROWS + 1);
	localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int DEPTH = PAGES * COLUMNS;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = ((HW > ska_pkg::SIZE_W) ? HW : ska_pkg::SIZE_W) + 1;

	ska_pkg::state_t state_q, state_d;

	logic [ska_pkg::SIZE_W-1:0] w_q, h_q;
	logic [PGW-1:0]             page_q;
	logic [CW-1:0]              c_q, rcnt_q, bx_q;
	logic [HW-1:0]              run_q, m_q, best_q;
	logic [AW-1:0]              clr_q;
	ska_pkg::res_t              res_q;

	// Height store and per-page scratch of block suffix maxima
	logic [HW-1:0] hmem [DEPTH];
	logic [HW-1:0] smem [COLUMNS];
	logic [AW-1:0] col_addr, h_waddr;
	logic          h_we, s_we;
	logic [HW-1:0] h_wdata, h_rd_q, s_rd_q;
	logic [CW-1:0] sidx;

	logic [HW-1:0] ua, ub, umax;
	logic          ult;

	logic          last_col, rc_at_top, win_ok, bad_req, fits, write_last, last_page;
	logic [SW-1:0] sum;

	ska_max_unit #(.HW(HW)) u_max (
		.a      (ua),
		.b      (ub),
		.max_val(umax),
		.a_lt_b (ult)
	);

	// Decode scan position and request checks
	assign col_addr   = AW'(32'(page_q) * COLUMNS + 32'(c_q));
	assign last_col   = (c_q == CW'(COLUMNS - 1));
	assign rc_at_top  = (32'(rcnt_q) + 32'd1 == 32'(w_q));
	assign win_ok     = (32'(c_q) + 32'd1 >= 32'(w_q));
	assign sidx       = CW'(32'(c_q) + 32'd1 - 32'(w_q));
	assign bad_req    = (w_q == '0) || (h_q == '0) || (32'(w_q) > COLUMNS);
	assign sum        = SW'(best_q) + SW'(h_q);
	assign fits       = (sum <= SW'(ROWS));
	assign write_last = (32'(c_q) + 32'd1 == 32'(bx_q) + 32'(w_q));
	assign last_page  = (32'(page_q) == PAGES - 1);

	// Route operands to the shared unit
	always_comb begin
		ua = '0;
		ub = '0;
		unique case (state_q)
			ska_pkg::ST_P1_USE: begin
				ua = h_rd_q;
				ub = (rcnt_q == '0) ? '0 : run_q;
			end
			ska_pkg::ST_P2_PRE: begin
				ua = h_rd_q;
				ub = ((c_q == '0) || rc_at_top) ? '0 : run_q;
			end
			ska_pkg::ST_P2_WIN: begin
				ua = s_rd_q;
				ub = run_q;
			end
			ska_pkg::ST_P2_CMP: begin
				ua = m_q;
				ub = best_q;
			end
			ska_pkg::ST_DECIDE: begin
				ua = best_q;
				ub = HW'(ROWS);
			end
			default: begin
				ua = '0;
				ub = '0;
			end
		endcase
	end

	// Memory write controls
	assign h_we    = (state_q == ska_pkg::ST_CLEAR) || (state_q == ska_pkg::ST_WRITE);
	assign h_waddr = (state_q == ska_pkg::ST_CLEAR) ? clr_q : col_addr;
	assign h_wdata = (state_q == ska_pkg::ST_CLEAR) ? '0 : HW'(sum);
	assign s_we    = (state_q == ska_pkg::ST_P1_USE);

	always_ff @(posedge clk) begin
		if (h_we) begin
			hmem[h_waddr] <= h_wdata;
		end
		h_rd_q <= hmem[col_addr];
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			smem[c_q] <= umax;
		end
		s_rd_q <= smem[sidx];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ska_pkg::ST_CLEAR:  if (clr_q == AW'(DEPTH - 1)) state_d = ska_pkg::ST_IDLE;
			ska_pkg::ST_IDLE:   if (req_valid) state_d = ska_pkg::ST_START;
			ska_pkg::ST_START:  state_d = bad_req ? ska_pkg::ST_DONE : ska_pkg::ST_P1_RD;
			ska_pkg::ST_P1_RD:  state_d = ska_pkg::ST_P1_USE;
			ska_pkg::ST_P1_USE: state_d = (c_q == '0) ? ska_pkg::ST_P2_RD : ska_pkg::ST_P1_RD;
			ska_pkg::ST_P2_RD:  state_d = ska_pkg::ST_P2_PRE;
			ska_pkg::ST_P2_PRE: begin
				priority if (win_ok) state_d = ska_pkg::ST_P2_WIN;
				else if (last_col)   state_d = ska_pkg::ST_DECIDE;
				else                 state_d = ska_pkg::ST_P2_RD;
			end
			ska_pkg::ST_P2_WIN: state_d = ska_pkg::ST_P2_CMP;
			ska_pkg::ST_P2_CMP: state_d = last_col ? ska_pkg::ST_DECIDE : ska_pkg::ST_P2_RD;
			ska_pkg::ST_DECIDE: begin
				priority if (ult && fits) state_d = ska_pkg::ST_WRITE;
				else if (last_page)       state_d = ska_pkg::ST_DONE;
				else                      state_d = ska_pkg::ST_P1_RD;
			end
			ska_pkg::ST_WRITE:  if (write_last) state_d = ska_pkg::ST_DONE;
			ska_pkg::ST_DONE:   if (out_free) state_d = ska_pkg::ST_IDLE;
			default:            state_d = ska_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ska_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ska_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// Scan datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ska_pkg::ST_IDLE: begin
				if (req_valid) begin
					w_q    <= req_data.rect_width;
					h_q    <= req_data.rect_height;
					page_q <= '0;
					res_q  <= '0;
				end
			end
			ska_pkg::ST_START: begin
				c_q    <= CW'(COLUMNS - 1);
				rcnt_q <= '0;
				best_q <= HW'(ROWS);
			end
			ska_pkg::ST_P1_USE: begin
				// Running max from the right, restarted at each block edge
				run_q <= umax;
				if (c_q != '0) begin
					c_q    <= c_q - CW'(1);
					rcnt_q <= rc_at_top ? '0 : rcnt_q + CW'(1);
				end
			end
			ska_pkg::ST_P2_PRE: begin
				// Running max from the left, restarted at each block edge
				run_q <= umax;
				if (!win_ok) begin
					c_q    <= c_q + CW'(1);
					rcnt_q <= (rcnt_q == '0) ? CW'(w_q - 9'd1) : rcnt_q - CW'(1);
				end
			end
			ska_pkg::ST_P2_WIN: begin
				m_q <= umax;
			end
			ska_pkg::ST_P2_CMP: begin
				// Keep the lowest window; strict compare keeps the leftmost
				if (ult) begin
					best_q <= m_q;
					bx_q   <= sidx;
				end
				c_q    <= c_q + CW'(1);
				rcnt_q <= (rcnt_q == '0) ? CW'(w_q - 9'd1) : rcnt_q - CW'(1);
			end
			ska_pkg::ST_DECIDE: begin
				if (ult && fits) begin
					c_q              <= bx_q;
					res_q.placed     <= 1'b1;
					res_q.page_index <= ska_pkg::PAGE_W'(page_q);
					res_q.pos_x      <= ska_pkg::POS_W'(bx_q);
					res_q.pos_y      <= ska_pkg::POS_W'(best_q);
				end else if (!last_page) begin
					page_q <= page_q + PGW'(1);
					c_q    <= CW'(COLUMNS - 1);
					rcnt_q <= '0;
					best_q <= HW'(ROWS);
				end
			end
			ska_pkg::ST_WRITE: begin
				c_q <= c_q + CW'(1);
			end
			default: begin
			end
		endcase
	end

	assign req_ready = (state_q == ska_pkg::ST_IDLE);
	assign done      = (state_q == ska_pkg::ST_DONE) && out_free;
	assign result    = res_q;

endmodule

[rtl/skyline_atlas_allocator_top.sv]
`timescale 1ns / 1ps

// Skyline rectangle allocator over PAGES atlas pages of COLUMNS x ROWS texels.
// Request beat (req_valid/req_ready/req_data) carries a width and a height;
// one result beat (res_valid/res_ready/res_data) follows each request with
// placed, page_index, pos_x and pos_y (all zero except placed = 0 on failure).
// Each page tried runs a right-to-left pass that builds block suffix maxima,
// then a left-to-right pass that runs the prefix max and, for window columns
// (all but the first width-1), the window max and the lowest-base compare,
// all through one shared max/compare unit and one read port on the height
// memory. A placement then writes the width chosen columns. Bad sizes skip
// the scan and go straight to the result. One request is worked at a time;
// req_ready is high only while idle. After reset the height memory is swept
// to zero, one entry per cycle, with req_ready low. The result sits in an
// output register: a new request is taken while it waits, but a finished
// search holds until the receiver takes the pending beat.
module skyline_atlas_allocator_top #(
	parameter int PAGES   = 1,
	parameter int COLUMNS = 256,
	parameter int ROWS    = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ska_pkg::req_t req_data,
	output logic          res_valid,
	input  logic          res_ready,
	output ska_pkg::res_t res_data
);

	logic          res_valid_q;
	ska_pkg::res_t res_data_q;
	logic          out_free, done;
	ska_pkg::res_t result;

	assign out_free = !res_valid_q || res_ready;

	ska_engine #(
		.PAGES  (PAGES),
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.out_free (out_free),
		.done     (done),
		.result   (result)
	);

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_data_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

endmodule

[rtl/ska_checker.sv]
`timescale 1ns / 1ps

// Port-level checks for the allocator
module ska_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          res_valid,
	input logic          res_ready,
	input ska_pkg::res_t res_data
);

	// Hold a stalled result beat
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result beat changed while stalled");

	// Failure reports carry zero position fields
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.placed |->
			res_data.page_index == '0 && res_data.pos_x == '0 && res_data.pos_y == '0)
		else $error("failed placement with nonzero fields");

	// Drop ready after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while search in flight");

	// Return to idle as the result appears
	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> req_ready)
		else $error("result raised without returning to idle");

endmodule

bind skyline_atlas_allocator_top ska_checker u_ska_checker (.*);
